// ===== hdl/rflpm_pkg.sv =====
// ----------------------------------------------------------------------------
// rflpm_pkg
// Shared types, codes and IEEE single helpers for the flash log pointer manager.
// ----------------------------------------------------------------------------
package rflpm_pkg;

  localparam int SECTOR_BYTES_DEF = 4096;
  localparam int HALF_BYTES_DEF   = 2097152;
  localparam int FLASH_BYTES_DEF  = 4194304;

  localparam int ADDR_W = 22;
  localparam int WORD_W = 32;
  localparam int CMD_W  = 3;
  localparam int FUNC_W = 2;

  localparam logic [WORD_W-1:0] ERASED_WORD = 32'hFFFF_FFFF;

  typedef enum logic [FUNC_W-1:0] {
    FN_START = 2'd0,
    FN_TICK  = 2'd1,
    FN_READ  = 2'd2,
    FN_DONE  = 2'd3
  } func_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE     = 3'd0,
    CMD_READ     = 3'd1,
    CMD_WRITE    = 3'd2,
    CMD_ERASE    = 3'd3,
    CMD_LOCAL_RS = 3'd4,
    CMD_MAST_RS  = 3'd5,
    CMD_ABORT    = 3'd6
  } cmd_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_L_SCAN  = 4'd1,
    PH_L_MID   = 4'd2,
    PH_L_NEXT  = 4'd3,
    PH_L_CHECK = 4'd4,
    PH_L_PREV  = 4'd5,
    PH_M_SCAN  = 4'd6,
    PH_M_MID   = 4'd7,
    PH_M_NEXT  = 4'd8,
    PH_M_CHECK = 4'd9,
    PH_M_PREV  = 4'd10,
    PH_W_LW    = 4'd11,
    PH_W_LE    = 4'd12,
    PH_W_MW    = 4'd13,
    PH_W_ME    = 4'd14
  } phase_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] address;
    logic [WORD_W-1:0] word;
    logic              last;
  } res_t;

  function automatic logic f_is_nan(input logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  endfunction

  function automatic logic f_is_zero(input logic [31:0] b);
    return b[30:0] == 31'd0;
  endfunction

  function automatic logic f_lt0(input logic [31:0] b);
    return b[31] && !f_is_nan(b) && !f_is_zero(b);
  endfunction

  // a <= b in IEEE order; any NaN compares false
  function automatic logic f_le(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ka;
    logic [31:0] kb;
    ka = a[31] ? ~a : {1'b1, a[30:0]};
    kb = b[31] ? ~b : {1'b1, b[30:0]};
    if (f_is_nan(a) || f_is_nan(b)) return 1'b0;
    if (f_is_zero(a) && f_is_zero(b)) return 1'b1;
    return ka <= kb;
  endfunction

endpackage

// ===== hdl/rflpm_if.sv =====
// ----------------------------------------------------------------------------
// rflpm channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface rflpm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] local_total;
  logic [31:0] main_total;
  logic [31:0] read_word;
  logic        write_ok;
  modport source (output valid, func, local_total, main_total, read_word, write_ok,
                  input ready);
  modport sink (input valid, func, local_total, main_total, read_word, write_ok,
                output ready);
endinterface

interface rflpm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [21:0] address;
  logic [31:0] word;
  logic        last;
  modport source (output valid, command, address, word, last, input ready);
  modport sink (input valid, command, address, word, last, output ready);
endinterface

// ===== hdl/rflpm_core.sv =====
// ----------------------------------------------------------------------------
// rflpm_core
// Pointer state and the single-pass decision for one registered item.
// ----------------------------------------------------------------------------
module rflpm_core #(
  parameter int SECTOR_BYTES = rflpm_pkg::SECTOR_BYTES_DEF,
  parameter int HALF_BYTES   = rflpm_pkg::HALF_BYTES_DEF,
  parameter int FLASH_BYTES  = rflpm_pkg::FLASH_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [1:0]          func,
  input  logic [31:0]         local_total,
  input  logic [31:0]         main_total,
  input  logic [31:0]         read_word,
  input  logic                write_ok,
  output rflpm_pkg::res_t     res0,
  output rflpm_pkg::res_t     res1,
  output logic [1:0]          res_cnt
);

  localparam int PW       = $clog2(FLASH_BYTES) + 1;
  localparam int SLSB     = $clog2(SECTOR_BYTES);
  localparam logic [PW-1:0] P_SECT  = PW'(SECTOR_BYTES);
  localparam logic [PW-1:0] P_HALF  = PW'(HALF_BYTES);
  localparam logic [PW-1:0] P_FLASH = PW'(FLASH_BYTES);
  localparam logic [PW-1:0] P_FOUR  = PW'(4);

  rflpm_pkg::phase_t phase_r, phase_nxt;
  logic [PW-1:0] lp_r, lp_nxt, mp_r, mp_nxt;
  logic [PW-1:0] sb0_r, sb0_nxt, sb1_r, sb1_nxt, sb2_r, sb2_nxt, sb3_r, sb3_nxt;
  logic [31:0]   last_saved_r, last_saved_nxt, held_l_r, held_l_nxt, held_m_r, held_m_nxt;
  logic          pend_r, pend_nxt, zsaved_r, zsaved_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= rflpm_pkg::PH_IDLE;
      lp_r         <= '0;
      mp_r         <= P_HALF;
      sb0_r        <= '0;
      sb1_r        <= '0;
      sb2_r        <= '0;
      sb3_r        <= '0;
      last_saved_r <= '0;
      held_l_r     <= '0;
      held_m_r     <= '0;
      pend_r       <= 1'b0;
      zsaved_r     <= 1'b0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      lp_r         <= lp_nxt;
      mp_r         <= mp_nxt;
      sb0_r        <= sb0_nxt;
      sb1_r        <= sb1_nxt;
      sb2_r        <= sb2_nxt;
      sb3_r        <= sb3_nxt;
      last_saved_r <= last_saved_nxt;
      held_l_r     <= held_l_nxt;
      held_m_r     <= held_m_nxt;
      pend_r       <= pend_nxt;
      zsaved_r     <= zsaved_nxt;
    end
  end

  logic          rgn;
  logic [PW-1:0] rstart, rend, cur_p, mid, sum_p;
  logic          do_search, do_check, do_fin, emit_v;
  logic [PW-1:0] chk_p;
  logic [31:0]   fin_word;
  logic [2:0]    e_cmd;
  logic [PW-1:0] e_addr;
  logic [31:0]   e_word;
  logic          go;

  always_comb begin
    phase_nxt      = phase_r;
    lp_nxt         = lp_r;
    mp_nxt         = mp_r;
    sb0_nxt        = sb0_r;
    sb1_nxt        = sb1_r;
    sb2_nxt        = sb2_r;
    sb3_nxt        = sb3_r;
    last_saved_nxt = last_saved_r;
    held_l_nxt     = held_l_r;
    held_m_nxt     = held_m_r;
    pend_nxt       = pend_r;
    zsaved_nxt     = zsaved_r;
    do_search = 1'b0;
    do_check  = 1'b0;
    do_fin    = 1'b0;
    chk_p     = '0;
    fin_word  = '0;
    emit_v    = 1'b0;
    e_cmd     = rflpm_pkg::CMD_NONE;
    e_addr    = '0;
    e_word    = '0;
    go        = 1'b0;
    mid       = '0;
    sum_p     = '0;
    res1      = '0;
    rgn    = (phase_r >= rflpm_pkg::PH_M_SCAN) && (phase_r <= rflpm_pkg::PH_M_PREV);
    rstart = rgn ? P_HALF : '0;
    rend   = rgn ? P_FLASH : P_HALF;
    cur_p  = rgn ? mp_r : lp_r;

    case (rflpm_pkg::func_t'(func))
      rflpm_pkg::FN_START: begin
        // begin the local region scan at the last word of its first sector
        sb0_nxt   = P_SECT - P_FOUR;
        phase_nxt = rflpm_pkg::PH_L_SCAN;
        emit_v    = 1'b1;
        e_cmd     = rflpm_pkg::CMD_READ;
        e_addr    = P_SECT - P_FOUR;
      end
      rflpm_pkg::FN_TICK: begin
        if (phase_r == rflpm_pkg::PH_IDLE) begin
          if (!pend_r) begin
            last_saved_nxt = local_total;
            pend_nxt       = 1'b1;
            go             = 1'b1;
          end else if (rflpm_pkg::f_le(local_total, last_saved_r)) begin
            if (rflpm_pkg::f_is_zero(local_total) && !zsaved_r) begin
              pend_nxt   = 1'b0;
              zsaved_nxt = 1'b1;
              go         = 1'b1;
            end
          end else if (!rflpm_pkg::f_lt0(local_total)) begin
            pend_nxt = 1'b0;
            go       = 1'b1;
          end
          if (go) begin
            held_l_nxt = local_total;
            held_m_nxt = main_total;
            phase_nxt  = rflpm_pkg::PH_W_LW;
            emit_v     = 1'b1;
            e_cmd      = rflpm_pkg::CMD_WRITE;
            e_addr     = lp_r;
            e_word     = local_total;
          end
        end
      end
      rflpm_pkg::FN_READ: begin
        case (phase_r)
          rflpm_pkg::PH_L_SCAN, rflpm_pkg::PH_M_SCAN: begin
            if (read_word == rflpm_pkg::ERASED_WORD) begin
              sb1_nxt   = sb0_r - (P_SECT - P_FOUR);
              sb2_nxt   = sb0_r;
              sb3_nxt   = rstart;
              do_search = 1'b1;
            end else if (sb0_r + P_SECT <= rend - PW'(3)) begin
              sb0_nxt = sb0_r + P_SECT;
              emit_v  = 1'b1;
              e_cmd   = rflpm_pkg::CMD_READ;
              e_addr  = sb0_r + P_SECT;
            end else begin
              do_check = 1'b1;
              chk_p    = rstart;
            end
          end
          rflpm_pkg::PH_L_MID, rflpm_pkg::PH_M_MID: begin
            if (read_word != rflpm_pkg::ERASED_WORD) begin
              phase_nxt = rgn ? rflpm_pkg::PH_M_NEXT : rflpm_pkg::PH_L_NEXT;
              emit_v    = 1'b1;
              e_cmd     = rflpm_pkg::CMD_READ;
              e_addr    = sb0_r + P_FOUR;
            end else if (sb0_r >= sb1_r + P_FOUR) begin
              sb2_nxt   = sb0_r - P_FOUR;
              do_search = 1'b1;
            end else begin
              do_check = 1'b1;
              chk_p    = sb3_r;
            end
          end
          rflpm_pkg::PH_L_NEXT, rflpm_pkg::PH_M_NEXT: begin
            if (read_word == rflpm_pkg::ERASED_WORD) begin
              do_check = 1'b1;
              chk_p    = sb0_r;
            end else begin
              sb3_nxt   = sb0_r;
              sb1_nxt   = sb0_r + P_FOUR;
              do_search = 1'b1;
            end
          end
          rflpm_pkg::PH_L_CHECK, rflpm_pkg::PH_M_CHECK: begin
            if (!rflpm_pkg::f_is_nan(read_word)) begin
              if (rgn) mp_nxt = cur_p + P_FOUR;
              else     lp_nxt = cur_p + P_FOUR;
              do_fin   = 1'b1;
              fin_word = read_word;
            end else begin
              phase_nxt = rgn ? rflpm_pkg::PH_M_PREV : rflpm_pkg::PH_L_PREV;
              emit_v    = 1'b1;
              e_cmd     = rflpm_pkg::CMD_READ;
              e_addr    = (cur_p >= P_FOUR) ? cur_p - P_FOUR : '0;
            end
          end
          rflpm_pkg::PH_L_PREV, rflpm_pkg::PH_M_PREV: begin
            do_fin   = 1'b1;
            fin_word = rflpm_pkg::f_is_nan(read_word) ? '0 : read_word;
          end
          default: ;
        endcase
      end
      rflpm_pkg::FN_DONE: begin
        if (phase_r >= rflpm_pkg::PH_W_LW && phase_r <= rflpm_pkg::PH_W_ME) begin
          if (!write_ok) begin
            phase_nxt = rflpm_pkg::PH_IDLE;
            emit_v    = 1'b1;
            e_cmd     = rflpm_pkg::CMD_ABORT;
          end else begin
            case (phase_r)
              rflpm_pkg::PH_W_LW, rflpm_pkg::PH_W_LE: begin
                sum_p = lp_r + P_FOUR;
                if (sum_p >= P_HALF) sum_p = '0;
                if (phase_r == rflpm_pkg::PH_W_LW && sum_p[SLSB-1:0] == '0) begin
                  lp_nxt    = sum_p;
                  phase_nxt = rflpm_pkg::PH_W_LE;
                  emit_v    = 1'b1;
                  e_cmd     = rflpm_pkg::CMD_ERASE;
                  e_addr    = sum_p;
                end else begin
                  if (phase_r == rflpm_pkg::PH_W_LW) lp_nxt = sum_p;
                  // master part: skip a negative master total
                  if (rflpm_pkg::f_lt0(held_m_r)) begin
                    phase_nxt = rflpm_pkg::PH_IDLE;
                  end else begin
                    phase_nxt = rflpm_pkg::PH_W_MW;
                    emit_v    = 1'b1;
                    e_cmd     = rflpm_pkg::CMD_WRITE;
                    e_addr    = mp_r;
                    e_word    = held_m_r;
                  end
                end
              end
              rflpm_pkg::PH_W_MW: begin
                sum_p = mp_r + P_FOUR;
                if (sum_p >= P_FLASH) sum_p = P_HALF;
                mp_nxt = sum_p;
                if (sum_p[SLSB-1:0] == '0) begin
                  phase_nxt = rflpm_pkg::PH_W_ME;
                  emit_v    = 1'b1;
                  e_cmd     = rflpm_pkg::CMD_ERASE;
                  e_addr    = sum_p;
                end else begin
                  phase_nxt = rflpm_pkg::PH_IDLE;
                end
              end
              default: phase_nxt = rflpm_pkg::PH_IDLE;
            endcase
          end
        end
      end
      default: ;
    endcase

    // next binary-search probe, or fall through to the pointer check
    if (do_search) begin
      if (sb1_nxt <= sb2_nxt) begin
        mid       = (sb1_nxt + ((sb2_nxt - sb1_nxt) >> 1)) & ~PW'(3);
        sb0_nxt   = mid;
        phase_nxt = rgn ? rflpm_pkg::PH_M_MID : rflpm_pkg::PH_L_MID;
        emit_v    = 1'b1;
        e_cmd     = rflpm_pkg::CMD_READ;
        e_addr    = mid;
      end else begin
        do_check = 1'b1;
        chk_p    = sb3_nxt;
      end
    end
    if (do_check) begin
      if (rgn) mp_nxt = chk_p;
      else     lp_nxt = chk_p;
      phase_nxt = rgn ? rflpm_pkg::PH_M_CHECK : rflpm_pkg::PH_L_CHECK;
      emit_v    = 1'b1;
      e_cmd     = rflpm_pkg::CMD_READ;
      e_addr    = chk_p;
    end
    if (do_fin) begin
      emit_v = 1'b1;
      e_cmd  = rgn ? rflpm_pkg::CMD_MAST_RS : rflpm_pkg::CMD_LOCAL_RS;
      e_addr = rgn ? mp_nxt : lp_nxt;
      e_word = fin_word;
      if (rgn) begin
        phase_nxt = rflpm_pkg::PH_IDLE;
      end else begin
        // local done: open the master region scan
        sb0_nxt       = P_HALF + P_SECT - P_FOUR;
        phase_nxt     = rflpm_pkg::PH_M_SCAN;
        res1.command  = rflpm_pkg::CMD_READ;
        res1.address  = rflpm_pkg::ADDR_W'(P_HALF + P_SECT - P_FOUR);
        res1.word     = '0;
        res1.last     = 1'b1;
      end
    end

    res0.command = e_cmd;
    res0.address = rflpm_pkg::ADDR_W'(e_addr);
    res0.word    = e_word;
    res0.last    = !(do_fin && !rgn);
    res_cnt      = (do_fin && !rgn) ? 2'd2 : (emit_v ? 2'd1 : 2'd0);
  end

endmodule

// ===== hdl/rflpm_outq.sv =====
// ----------------------------------------------------------------------------
// rflpm_outq
// Four-entry result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module rflpm_outq (
  input  logic            clk,
  input  logic            rst_n,
  input  rflpm_pkg::res_t push0,
  input  rflpm_pkg::res_t push1,
  input  logic [1:0]      push_cnt,
  input  logic            pop,
  output rflpm_pkg::res_t head,
  output logic            not_empty,
  output logic [2:0]      count
);

  rflpm_pkg::res_t mem_r [4];
  logic [1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = wp_r + push_cnt;
    rp_nxt  = rp_r + 2'(pop);
    cnt_nxt = cnt_r + 3'(push_cnt) - 3'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem_r[wp_r] <= push0;
    if (push_cnt == 2'd2) mem_r[wp_r + 2'd1] <= push1;
  end

  assign head      = mem_r[rp_r];
  assign not_empty = cnt_r != 3'd0;
  assign count     = cnt_r;

endmodule

// ===== hdl/rolling_flash_log_pointer_manager_unit.sv =====
// ----------------------------------------------------------------------------
// rolling_flash_log_pointer_manager_unit
// Write-pointer recovery and save sequencing for two rolling flash logs.
// ----------------------------------------------------------------------------
// Each item is captured in an input register, decided combinationally against
// the pointer state, and its results (one, or two when the local log finishes
// recovery and the master scan opens) go into a four-entry result queue. With
// the result side draining, one item is taken every cycle while the queue
// keeps two entries free; the queue drains one result per cycle, so two-result
// items can hold the input. Items are held in the input register while the
// queue has fewer than two free entries; results are registered in the queue.
module rolling_flash_log_pointer_manager_unit #(
  parameter int SECTOR_BYTES = rflpm_pkg::SECTOR_BYTES_DEF,
  parameter int HALF_BYTES   = rflpm_pkg::HALF_BYTES_DEF,
  parameter int FLASH_BYTES  = rflpm_pkg::FLASH_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rflpm_in_if.sink    in_ch,
  rflpm_out_if.source out_ch
);

  // input register
  logic        iv_r, iv_nxt;
  logic [1:0]  func_r;
  logic [31:0] lt_r, mt_r, rw_r;
  logic        ok_r;
  logic        fire;
  logic        in_xfer;

  rflpm_pkg::res_t r0, r1, head;
  logic [1:0]      rcnt;
  logic [2:0]      qcount;
  logic            q_ne;

  // decide only when the queue can take both possible results
  assign fire         = iv_r && (qcount <= 3'd2);
  assign in_ch.ready  = !iv_r || fire;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  always_comb begin
    iv_nxt = iv_r;
    if (in_xfer)   iv_nxt = 1'b1;
    else if (fire) iv_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else begin
      iv_r <= iv_nxt;
    end
  end

  // hold payload until the item is decided
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      func_r <= in_ch.func;
      lt_r   <= in_ch.local_total;
      mt_r   <= in_ch.main_total;
      rw_r   <= in_ch.read_word;
      ok_r   <= in_ch.write_ok;
    end
  end

  rflpm_core #(
    .SECTOR_BYTES (SECTOR_BYTES),
    .HALF_BYTES   (HALF_BYTES),
    .FLASH_BYTES  (FLASH_BYTES)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .func         (func_r),
    .local_total  (lt_r),
    .main_total   (mt_r),
    .read_word    (rw_r),
    .write_ok     (ok_r),
    .res0         (r0),
    .res1         (r1),
    .res_cnt      (rcnt)
  );

  rflpm_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0     (r0),
    .push1     (r1),
    .push_cnt  (fire ? rcnt : 2'd0),
    .pop       (out_ch.valid && out_ch.ready),
    .head      (head),
    .not_empty (q_ne),
    .count     (qcount)
  );

  assign out_ch.valid   = q_ne;
  assign out_ch.command = head.command;
  assign out_ch.address = head.address;
  assign out_ch.word    = head.word;
  assign out_ch.last    = head.last;

`ifndef SYNTHESIS
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n) qcount <= 3'd4)
    else $error("result queue overflow");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |=> iv_r)
    else $error("held item lost while stalled");
  a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && rcnt == 2'd2) |-> (!r0.last && r1.last))
    else $error("last flag misplaced on result pair");
`endif

endmodule
